// ----- hw/rtl/lsvm_pkg.sv -----
package lsvm_pkg;

	localparam int MAX_VECTORS_DEF = 16;
	localparam int MODELS          = 3;
	localparam int FEAT_W          = 16;
	localparam int CNT_W           = 5;
	localparam int DEC_W           = 48;
	localparam int PROD_W          = 32;
	localparam int DOT_W           = 33;
	localparam int TERM_W          = 49;
	localparam int ACC_W           = 56;
	localparam int CFG_IDX_W       = 3;
	localparam int TAG_W           = 2;

	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_C  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_C = 3'd5;

	localparam logic [1:0] CLASS_0 = 2'd0;
	localparam logic [1:0] CLASS_1 = 2'd1;
	localparam logic [1:0] CLASS_2 = 2'd2;

	typedef logic signed [FEAT_W-1:0] feat_t;
	typedef logic signed [DEC_W-1:0]  dec_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic finish;
	} mac_ctrl_t;

endpackage

// ----- hw/rtl/linear_svm_one_vs_one_classifier_core.sv -----
// Three-class one-versus-one linear SVM over two Q3.12 features.
//
// Command channel: drive start with the input word; it is taken on a rising
// edge where start is high and busy is low. A load word (func low) writes one
// support vector and alpha into the table of one classifier at that edge and
// leaves the block idle, so loads may follow back to back. A classify word
// raises busy until its result has been shown.
// Result channel: done is high for exactly one cycle with class_id and the
// three saturated Q11.36 decision values; the receiver cannot stall, so take
// the word in that cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while busy is low.
// Timing: one shared multiply-accumulate pipeline takes one table term per
// cycle, from two table memories that share one read address, while a table
// has terms left, with an idle step after each classifier's table; then it
// drains until the last term is accumulated, a finish step adds the biases
// and saturates, and a result step shows done; busy drops the next cycle.
// Empty trailing tables let the drain overlap the idle steps.
// Reset: counts and biases clear to zero and the sequencer goes idle; the
// tables are not cleared and must be loaded before they are used.
module linear_svm_one_vs_one_classifier_core #(
	parameter int MAX_VECTORS = lsvm_pkg::MAX_VECTORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [1:0]                        which_model,
	input  logic [3:0]                        entry_index,
	input  lsvm_pkg::feat_t                   vector_x,
	input  lsvm_pkg::feat_t                   vector_y,
	input  lsvm_pkg::feat_t                   weight,
	input  lsvm_pkg::feat_t                   sample_x,
	input  lsvm_pkg::feat_t                   sample_y,
	output logic                              done,
	output logic [1:0]                        class_id,
	output lsvm_pkg::dec_t                    decision_a,
	output lsvm_pkg::dec_t                    decision_b,
	output lsvm_pkg::dec_t                    decision_c,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsvm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsvm_pkg::DEC_W-1:0]        cfg_data
);

	import lsvm_pkg::*;

	localparam int          DEPTH = MODELS * MAX_VECTORS;
	localparam int          AW    = $clog2(DEPTH);
	localparam logic [31:0] MAXV  = 32'(MAX_VECTORS);
	localparam logic [TAG_W-1:0] LAST_MODEL = TAG_W'(MODELS - 1);

	state_t           state_q, state_d;
	cnt_t             count_q [MODELS];
	dec_t             offset_q [MODELS];
	cnt_t             n_sat [MODELS];
	logic [TAG_W-1:0] k_q;
	cnt_t             i_q;
	feat_t            sx_q, sy_q;
	logic             rd_vld_q;
	logic [TAG_W-1:0] rd_tag_q;

	logic             accept, load_we, classify, issue, last_model;
	logic [AW-1:0]    waddr, raddr;
	logic [31:0]      vec_rdata;
	feat_t            alpha_rdata;
	mac_ctrl_t        mac_ctrl;
	logic             mac_busy;
	dec_t             dec [MODELS];
	logic             pos_a, pos_b, pos_c;
	logic [1:0]       votes_0, votes_1, votes_2;

	assign accept   = start & ~busy;
	assign classify = accept & (func == FUNC_CLASSIFY);
	// drop loads aimed at a fourth table or beyond the table depth
	assign load_we  = accept & (func == FUNC_LOAD) & (which_model < TAG_W'(MODELS))
		& ({28'd0, entry_index} < MAXV);
	assign waddr    = AW'(which_model) * AW'(MAX_VECTORS) + AW'(entry_index);
	assign raddr    = AW'(k_q) * AW'(MAX_VECTORS) + AW'(i_q);

	// clamp each count to the table depth
	always_comb begin
		for (int k = 0; k < MODELS; k++) begin
			n_sat[k] = ({27'd0, count_q[k]} > MAXV) ? CNT_W'(MAX_VECTORS) : count_q[k];
		end
	end

	assign last_model = (k_q == LAST_MODEL);
	assign issue      = (state_q == ST_RUN) && (i_q < n_sat[k_q]);

	// configuration registers; ignore indexes past the list
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MODELS; k++) begin
				count_q[k]  <= '0;
				offset_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COUNT_A:  count_q[0]  <= cfg_data[CNT_W-1:0];
				CFG_COUNT_B:  count_q[1]  <= cfg_data[CNT_W-1:0];
				CFG_COUNT_C:  count_q[2]  <= cfg_data[CNT_W-1:0];
				CFG_OFFSET_A: offset_q[0] <= cfg_data;
				CFG_OFFSET_B: offset_q[1] <= cfg_data;
				CFG_OFFSET_C: offset_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			i_q      <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issue;
			if (classify) begin
				k_q <= '0;
				i_q <= '0;
			end else if (issue) begin
				i_q <= i_q + CNT_W'(1);
			end else if (state_q == ST_RUN && !last_model) begin
				// advance to the next classifier's table
				k_q <= k_q + TAG_W'(1);
				i_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_q <= k_q;
		if (classify) begin
			sx_q <= sample_x;
			sy_q <= sample_y;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (classify) state_d = ST_RUN;
			ST_RUN:    if (!issue && last_model) state_d = ST_DRAIN;
			// hold until the last term has reached its accumulator
			ST_DRAIN:  if (!mac_busy) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = 1'b1;
		done            = 1'b0;
		mac_ctrl.clear  = classify;
		mac_ctrl.finish = 1'b0;
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_FINISH: mac_ctrl.finish = 1'b1;
			ST_DONE:   done = 1'b1;
			default: ;
		endcase
	end

	lsvm_ram #(
		.WIDTH(2 * FEAT_W),
		.DEPTH(DEPTH)
	) u_vec_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(waddr),
		.wdata({vector_y, vector_x}),
		.raddr(raddr),
		.rdata(vec_rdata)
	);

	lsvm_ram #(
		.WIDTH(FEAT_W),
		.DEPTH(DEPTH)
	) u_alpha_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(waddr),
		.wdata(weight),
		.raddr(raddr),
		.rdata(alpha_rdata)
	);

	lsvm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.in_valid(rd_vld_q),
		.in_tag  (rd_tag_q),
		.vec_x   (vec_rdata[FEAT_W-1:0]),
		.vec_y   (vec_rdata[2*FEAT_W-1:FEAT_W]),
		.alpha   (alpha_rdata),
		.smp_x   (sx_q),
		.smp_y   (sy_q),
		.bias    (offset_q),
		.busy    (mac_busy),
		.dec     (dec)
	);

	// vote: a strictly positive decision picks the first class of the pair
	assign pos_a   = (dec[0] > 0);
	assign pos_b   = (dec[1] > 0);
	assign pos_c   = (dec[2] > 0);
	assign votes_0 = {1'b0, pos_a} + {1'b0, pos_b};
	assign votes_1 = {1'b0, ~pos_a} + {1'b0, pos_c};
	assign votes_2 = {1'b0, ~pos_b} + {1'b0, ~pos_c};

	// ties go to the lower class
	always_comb begin
		class_id = CLASS_0;
		if (votes_1 > votes_0) begin
			class_id = CLASS_1;
			if (votes_2 > votes_1) class_id = CLASS_2;
		end else if (votes_2 > votes_0) begin
			class_id = CLASS_2;
		end
	end

	assign decision_a = dec[0];
	assign decision_b = dec[1];
	assign decision_c = dec[2];

endmodule

// ----- hw/rtl/lsvm_ram.sv -----
module lsvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/lsvm_mac.sv -----
module lsvm_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsvm_pkg::mac_ctrl_t                 ctrl,
	input  logic                                in_valid,
	input  logic [lsvm_pkg::TAG_W-1:0]          in_tag,
	input  lsvm_pkg::feat_t                     vec_x,
	input  lsvm_pkg::feat_t                     vec_y,
	input  lsvm_pkg::feat_t                     alpha,
	input  lsvm_pkg::feat_t                     smp_x,
	input  lsvm_pkg::feat_t                     smp_y,
	input  lsvm_pkg::dec_t                      bias [lsvm_pkg::MODELS],
	output logic                                busy,
	output lsvm_pkg::dec_t                      dec [lsvm_pkg::MODELS]
);

	import lsvm_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(signed'({1'b0, {(DEC_W-1){1'b1}}}));
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	logic                     vld_s1, vld_s2, vld_s3;
	logic [TAG_W-1:0]         tag_s1, tag_s2, tag_s3;
	logic signed [PROD_W-1:0] px_s1, py_s1;
	feat_t                    a_s1, a_s2;
	logic signed [DOT_W-1:0]  dot_s2;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [ACC_W-1:0]  acc_q [MODELS];
	logic signed [ACC_W-1:0]  total [MODELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// feature products, then dot product, then scale by alpha
	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		px_s1   <= PROD_W'(vec_x) * PROD_W'(smp_x);
		py_s1   <= PROD_W'(vec_y) * PROD_W'(smp_y);
		a_s1    <= alpha;
		tag_s2  <= tag_s1;
		dot_s2  <= DOT_W'(px_s1) + DOT_W'(py_s1);
		a_s2    <= a_s1;
		tag_s3  <= tag_s2;
		term_s3 <= TERM_W'(dot_s2) * TERM_W'(a_s2);
	end

	always_comb begin
		for (int k = 0; k < MODELS; k++) begin
			total[k] = acc_q[k] + ACC_W'(bias[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MODELS; k++) begin
			if (ctrl.clear) begin
				acc_q[k] <= '0;
			end else if (vld_s3 && tag_s3 == TAG_W'(k)) begin
				acc_q[k] <= acc_q[k] + ACC_W'(term_s3);
			end
			if (ctrl.finish) begin
				if (total[k] > SAT_HI) begin
					dec[k] <= DEC_W'(SAT_HI);
				end else if (total[k] < SAT_LO) begin
					dec[k] <= DEC_W'(SAT_LO);
				end else begin
					dec[k] <= total[k][DEC_W-1:0];
				end
			end
		end
	end

	assign busy = in_valid | vld_s1 | vld_s2 | vld_s3;

endmodule
